[sv/assert_macros.svh]
// shared assertion macros for the rotation segmenter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/carseg_pkg.sv]
// ----------------------------------------------------------------------------
// carseg_pkg
// types and constants shared by the capture archive rotation segmenter
// ----------------------------------------------------------------------------
package carseg_pkg;

  localparam logic [47:0] HEADER_BYTES    = 48'd36;
  localparam logic [47:0] RECORD_OVERHEAD = 48'd16;
  localparam logic [31:0] MAX32           = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48           = 48'hFFFF_FFFF_FFFF;

  // register indexes on the config port
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_RECORDS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_PAYLOAD  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_SPAN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_FILE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_IDLE_GAP = 3'd4;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_RECORDS  = 3'd1,
    CAUSE_PAYLOAD  = 3'd2,
    CAUSE_SPAN     = 3'd3,
    CAUSE_FILE     = 3'd4,
    CAUSE_IDLE_GAP = 3'd5
  } cause_t;

  typedef struct packed {
    logic [63:0] capture_time;
    logic [15:0] payload_length;
  } record_t;

  typedef struct packed {
    logic        rotated;
    logic [2:0]  rotate_cause;
    logic [31:0] shard_number;
    logic [31:0] position_in_shard;
    logic [31:0] closed_count;
    logic [47:0] closed_payload;
    logic [47:0] closed_file_size;
    logic [63:0] closed_first_time;
    logic [63:0] closed_last_time;
  } result_t;

  typedef struct packed {
    logic [31:0] records;
    logic [47:0] payload_cap;
    logic [63:0] span_ns;
    logic [47:0] file_bytes;
    logic [63:0] gap_ns;
  } limits_t;

endpackage

[sv/carseg_csr.sv]
// ----------------------------------------------------------------------------
// carseg_csr
// limit registers behind the APB-style config port
// ----------------------------------------------------------------------------
module carseg_csr (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [5:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  output carseg_pkg::limits_t    limits
);

  logic [carseg_pkg::REG_IDX_W-1:0] idx;
  logic                             wr_en;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits <= '0;
    end else if (wr_en) begin
      case (idx)
        carseg_pkg::REG_LIMIT_RECORDS:  limits.records     <= pwdata[31:0];
        carseg_pkg::REG_LIMIT_PAYLOAD:  limits.payload_cap <= pwdata[47:0];
        carseg_pkg::REG_LIMIT_SPAN:     limits.span_ns     <= pwdata;
        carseg_pkg::REG_LIMIT_FILE:     limits.file_bytes  <= pwdata[47:0];
        carseg_pkg::REG_LIMIT_IDLE_GAP: limits.gap_ns      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      carseg_pkg::REG_LIMIT_RECORDS:  prdata = {32'd0, limits.records};
      carseg_pkg::REG_LIMIT_PAYLOAD:  prdata = {16'd0, limits.payload_cap};
      carseg_pkg::REG_LIMIT_SPAN:     prdata = limits.span_ns;
      carseg_pkg::REG_LIMIT_FILE:     prdata = {16'd0, limits.file_bytes};
      carseg_pkg::REG_LIMIT_IDLE_GAP: prdata = limits.gap_ns;
      default:                        prdata = 64'd0;
    endcase
  end

endmodule

[sv/carseg_core.sv]
// ----------------------------------------------------------------------------
// carseg_core
// open-shard state, limit checks and next-state logic for one record
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module carseg_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  carseg_pkg::record_t  rec,
  input  carseg_pkg::limits_t  limits,
  output carseg_pkg::result_t  res
);

  logic [31:0] records;
  logic [47:0] payload;
  logic [63:0] first_time;
  logic [63:0] last_time;
  logic [47:0] estimate;
  logic [31:0] shard;

  logic [31:0] records_next;
  logic [47:0] payload_next;
  logic [63:0] first_time_next;
  logic [63:0] last_time_next;
  logic [47:0] estimate_next;
  logic [31:0] shard_next;

  logic [63:0] t;
  logic [15:0] len;
  logic        empty;
  logic [63:0] lo;
  logic [63:0] hi;
  logic [48:0] pay_check;
  logic [48:0] file_check;
  logic        hit_records;
  logic        hit_payload;
  logic        hit_span;
  logic        hit_file;
  logic        hit_idle;
  carseg_pkg::cause_t cause;
  logic        rotate;
  logic        fresh;
  logic [31:0] base_records;
  logic [47:0] base_payload;
  logic [47:0] base_estimate;
  logic [48:0] pay_sum;
  logic [48:0] est_sum;
  logic        shard_bump;

  assign t     = rec.capture_time;
  assign len   = rec.payload_length;
  assign empty = (records == 32'd0);

  // limit checks, all at full precision
  always_comb begin
    lo         = (t < first_time) ? t : first_time;
    hi         = (t > last_time) ? t : last_time;
    pay_check  = {1'b0, payload} + {33'd0, len};
    file_check = {1'b0, estimate} + {1'b0, carseg_pkg::RECORD_OVERHEAD} + {33'd0, len};

    hit_records = (limits.records != 32'd0) && (records >= limits.records);
    hit_payload = (limits.payload_cap != 48'd0) &&
                  (pay_check > {1'b0, limits.payload_cap});
    hit_span    = (limits.span_ns != 64'd0) && ((hi - lo) > limits.span_ns);
    hit_file    = (limits.file_bytes != 48'd0) &&
                  (file_check > {1'b0, limits.file_bytes});
    hit_idle    = (limits.gap_ns != 64'd0) && (t > last_time) &&
                  ((t - last_time) > limits.gap_ns);

    if (empty)            cause = carseg_pkg::CAUSE_NONE;
    else if (hit_records) cause = carseg_pkg::CAUSE_RECORDS;
    else if (hit_payload) cause = carseg_pkg::CAUSE_PAYLOAD;
    else if (hit_span)    cause = carseg_pkg::CAUSE_SPAN;
    else if (hit_file)    cause = carseg_pkg::CAUSE_FILE;
    else if (hit_idle)    cause = carseg_pkg::CAUSE_IDLE_GAP;
    else                  cause = carseg_pkg::CAUSE_NONE;
    rotate = (cause != carseg_pkg::CAUSE_NONE);
  end

  // append the record to the open shard, or to a fresh one
  always_comb begin
    base_records  = rotate ? 32'd0 : records;
    base_payload  = rotate ? 48'd0 : payload;
    fresh         = (base_records == 32'd0);
    base_estimate = fresh ? carseg_pkg::HEADER_BYTES : estimate;

    first_time_next = (fresh || t < first_time) ? t : first_time;
    last_time_next  = (fresh || t > last_time) ? t : last_time;

    records_next = (base_records == carseg_pkg::MAX32) ? carseg_pkg::MAX32
                                                       : base_records + 32'd1;
    pay_sum      = {1'b0, base_payload} + {33'd0, len};
    payload_next = pay_sum[48] ? carseg_pkg::MAX48 : pay_sum[47:0];
    est_sum      = {1'b0, base_estimate} + {1'b0, carseg_pkg::RECORD_OVERHEAD} +
                   {33'd0, len};
    estimate_next = est_sum[48] ? carseg_pkg::MAX48 : est_sum[47:0];

    shard_next = (rotate && shard != carseg_pkg::MAX32) ? shard + 32'd1 : shard;
  end

  always_comb begin
    res.rotated           = rotate;
    res.rotate_cause      = cause;
    res.shard_number      = shard_next;
    res.position_in_shard = records_next;
    res.closed_count      = rotate ? records : 32'd0;
    res.closed_payload    = rotate ? payload : 48'd0;
    res.closed_file_size  = rotate ? estimate : 48'd0;
    res.closed_first_time = rotate ? first_time : 64'd0;
    res.closed_last_time  = rotate ? last_time : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      records    <= 32'd0;
      payload    <= 48'd0;
      first_time <= 64'd0;
      last_time  <= 64'd0;
      estimate   <= carseg_pkg::HEADER_BYTES;
      shard      <= 32'd0;
    end else if (step) begin
      records    <= records_next;
      payload    <= payload_next;
      first_time <= first_time_next;
      last_time  <= last_time_next;
      estimate   <= estimate_next;
      shard      <= shard_next;
    end
  end

  // a rotating step below the saturation point
  assign shard_bump = step && rotate && (shard != carseg_pkg::MAX32);

  `ASSERT_NEXT(a_step_fills_shard, clk, rst, step, records != 32'd0)
  `ASSERT_NEXT(a_rotate_advances, clk, rst, shard_bump, shard == $past(shard) + 32'd1)
  `ASSERT_IMPL(a_time_order, clk, rst, records != 32'd0, first_time <= last_time)
  `ASSERT_ALWAYS(a_estimate_floor, clk, rst, estimate >= carseg_pkg::HEADER_BYTES)

endmodule

[sv/capture_archive_rotation_segmenter_unit.sv]
// ----------------------------------------------------------------------------
// capture_archive_rotation_segmenter_unit
// splits a stream of capture records into archive shards by five limits
// ----------------------------------------------------------------------------
// The unit takes one capture record per clock and returns exactly one result
// beat per record, in order. A record sits first in an input register; the
// limit checks and the shard update run in one pass of adds and compares
// between that register and the result register, which loads a record's result
// beat as the record leaves the input register. The sustained rate is one record
// per cycle, limited only by the downstream ready. The shard state
// (count, payload sum, first and last time, file estimate, shard index) lives
// in flip-flops and needs no clearing pass after reset. Limits are programmed
// over the APB-style port at byte address 8*i (records, payload bytes, span,
// file bytes, idle gap); a zero limit is off, and limits should only change
// while no record is in flight.
module capture_archive_rotation_segmenter_unit (
  input  logic                 clk,
  input  logic                 rst,
  // record channel
  input  logic                 record_valid,
  output logic                 record_ready,
  input  carseg_pkg::record_t  record_data,
  // result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output carseg_pkg::result_t  result_data,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  carseg_pkg::limits_t limits;

  // input register
  logic                rin_valid;
  carseg_pkg::record_t rin;

  // core result for the record in the input register
  carseg_pkg::result_t core_res;

  // record moves on when the result register is free or being drained
  logic advance;

  assign advance      = rin_valid && (!result_valid || result_ready);
  assign record_ready = !rin_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      rin_valid <= 1'b0;
    end else if (record_ready) begin
      rin_valid <= record_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (record_ready && record_valid) begin
      rin <= record_data;
    end
  end

  // result register, refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= rin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_data <= core_res;
    end
  end

  carseg_csr u_csr (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  // shard state advances exactly once per beat leaving the input register
  carseg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .rec    (rin),
    .limits (limits),
    .res    (core_res)
  );

endmodule

[tb/sv/shard_rotation_checker.sv]
// ----------------------------------------------------------------------------
// shard_rotation_checker
// watches the record, result and config channels of the rotation segmenter,
// keeps its own copy of the open shard and the limits, predicts one result
// beat per accepted record and compares each result beat field by field
// ----------------------------------------------------------------------------
module shard_rotation_checker
  import carseg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    record_valid,
  input  logic    record_ready,
  input  record_t record_data,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result_data,
  input  logic    psel,
  input  logic    penable,
  input  logic    pwrite,
  input  logic    pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int      failures,
  output int      pending,
  output int      checked,
  output int      rotations
);

  limits_t     limits;
  logic [31:0] shard_count;
  logic [47:0] shard_payload;
  logic [63:0] shard_first;
  logic [63:0] shard_last;
  logic [47:0] shard_file_est;
  logic [31:0] shard_seq;

  result_t awaited_results[$];
  result_t want;

  initial begin
    failures  = 0;
    pending   = 0;
    checked   = 0;
    rotations = 0;
  end

  task automatic report_fault(input string msg);
    $display("%0t rotation checker: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) begin
      report_fault($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                             checked, name, got, exp_val));
    end
  endtask

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == MAX32) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [16:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {32'd0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic void open_empty_shard();
    shard_count    = '0;
    shard_payload  = '0;
    shard_first    = '0;
    shard_last     = '0;
    shard_file_est = HEADER_BYTES;
  endfunction

  // first limit that trips, in priority order; sums kept at 65 bits
  function automatic cause_t rotation_cause(input record_t rec);
    logic [64:0] payload_total;
    logic [64:0] file_total;
    logic [63:0] lo;
    logic [63:0] hi;
    if (shard_count == '0) return CAUSE_NONE;
    if (limits.records != '0 && shard_count >= limits.records) return CAUSE_RECORDS;
    payload_total = 65'(shard_payload) + 65'(rec.payload_length);
    if (limits.payload_cap != '0 && payload_total > 65'(limits.payload_cap))
      return CAUSE_PAYLOAD;
    lo = (rec.capture_time < shard_first) ? rec.capture_time : shard_first;
    hi = (rec.capture_time > shard_last) ? rec.capture_time : shard_last;
    if (limits.span_ns != '0 && hi - lo > limits.span_ns) return CAUSE_SPAN;
    file_total = 65'(shard_file_est) + 65'(RECORD_OVERHEAD) + 65'(rec.payload_length);
    if (limits.file_bytes != '0 && file_total > 65'(limits.file_bytes)) return CAUSE_FILE;
    if (limits.gap_ns != '0 && rec.capture_time > shard_last
        && rec.capture_time - shard_last > limits.gap_ns)
      return CAUSE_IDLE_GAP;
    return CAUSE_NONE;
  endfunction

  // appends one record to the shard model and returns its result beat
  function automatic result_t next_shard_result(input record_t rec);
    result_t res;
    cause_t  cause;
    res   = '0;
    cause = rotation_cause(rec);
    if (cause != CAUSE_NONE) begin
      res.rotated           = 1'b1;
      res.closed_count      = shard_count;
      res.closed_payload    = shard_payload;
      res.closed_file_size  = shard_file_est;
      res.closed_first_time = shard_first;
      res.closed_last_time  = shard_last;
      open_empty_shard();
      shard_seq = inc_sat32(shard_seq);
    end
    res.rotate_cause = cause;
    if (shard_count == '0) begin
      shard_first    = rec.capture_time;
      shard_last     = rec.capture_time;
      shard_file_est = HEADER_BYTES;
    end else begin
      if (rec.capture_time < shard_first) shard_first = rec.capture_time;
      if (rec.capture_time > shard_last) shard_last = rec.capture_time;
    end
    shard_count    = inc_sat32(shard_count);
    shard_payload  = add_sat48(shard_payload, {1'b0, rec.payload_length});
    shard_file_est = add_sat48(shard_file_est,
                               17'(RECORD_OVERHEAD) + 17'(rec.payload_length));
    res.shard_number      = shard_seq;
    res.position_in_shard = shard_count;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      limits = '0;
      open_empty_shard();
      shard_seq = '0;
      awaited_results.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_LIMIT_RECORDS:  limits.records     = pwdata[31:0];
          REG_LIMIT_PAYLOAD:  limits.payload_cap = pwdata[47:0];
          REG_LIMIT_SPAN:     limits.span_ns     = pwdata;
          REG_LIMIT_FILE:     limits.file_bytes  = pwdata[47:0];
          REG_LIMIT_IDLE_GAP: limits.gap_ns      = pwdata;
          default: ;
        endcase
      end
      if (record_valid && record_ready) begin
        awaited_results.insert(awaited_results.size(), next_shard_result(record_data));
      end
      if (result_valid === 1'b1 && result_ready) begin
        if (awaited_results.size() == 0) begin
          report_fault("result beat with no record waiting for it");
        end else begin
          want = awaited_results.pop_front();
          check_field("rotated", result_data.rotated, want.rotated);
          check_field("rotate_cause", result_data.rotate_cause, want.rotate_cause);
          check_field("shard_number", result_data.shard_number, want.shard_number);
          check_field("position_in_shard", result_data.position_in_shard,
                      want.position_in_shard);
          check_field("closed_count", result_data.closed_count, want.closed_count);
          check_field("closed_payload", result_data.closed_payload, want.closed_payload);
          check_field("closed_file_size", result_data.closed_file_size,
                      want.closed_file_size);
          check_field("closed_first_time", result_data.closed_first_time,
                      want.closed_first_time);
          check_field("closed_last_time", result_data.closed_last_time,
                      want.closed_last_time);
          checked++;
          if (want.rotated) rotations++;
        end
      end
      pending = awaited_results.size();
    end
  end

endmodule

[tb/sv/tb_capture_archive_rotation_segmenter_unit.sv]
// ----------------------------------------------------------------------------
// tb_capture_archive_rotation_segmenter_unit
// drives capture records and limit settings into the rotation segmenter;
// a checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
// a directed pass walks each rotation cause, the priority order, out-of-order
// timestamps and the extreme field values; then paced random phases run with
// fresh limits each, including all-ones and minimum limits, a long receiver
// hold-off that backs the block up, and a sender pause until it drains
module tb_capture_archive_rotation_segmenter_unit;
  import carseg_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 85;

  // address slot past the register list, writes there must be ignored
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;

  // pacing of the two channels in a phase
  typedef enum int {
    PACE_STEADY,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH_LIGHT
  } pace_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        record_valid = 1'b0;
  logic        record_ready;
  record_t     record_data  = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result_data;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [5:0]  paddr        = '0;
  logic [63:0] pwdata       = '0;
  logic [63:0] prdata;
  logic        pready;

  // pacing knobs, in percent
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // long hold-off handshake between stimulus and the receiver process
  int hold_go   = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int cycles = 0;
  int sent   = 0;

  // checker outputs
  int failures;
  int pending;
  int checked;
  int rotations;

  always #CLK_HALF clk = ~clk;

  capture_archive_rotation_segmenter_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record_data  (record_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  shard_rotation_checker u_rotation_checker (
    .clk          (clk),
    .rst          (rst),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record_data  (record_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .failures     (failures),
    .pending      (pending),
    .checked      (checked),
    .rotations    (rotations)
  );

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles, pending);
      $display("tb_capture_archive_rotation_segmenter_unit: FAIL");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen    <= hold_go;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offer one record beat, with random idle cycles ahead of it
  task automatic send_record(input record_t rec);
    while ($urandom_range(99) < tx_idle_pct) begin
      record_valid <= 1'b0;
      @(posedge clk);
    end
    record_valid <= 1'b1;
    record_data  <= rec;
    @(posedge clk);
    while (!record_ready) @(posedge clk);
    sent++;
  endtask

  // stop offering, wait for every owed result beat, then let the pipe settle
  task automatic quiesce();
    record_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup cycle, access cycle, then idle so the next write starts clean
  task automatic program_limit(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_all(input logic [63:0] recs, input logic [63:0] payload,
                             input logic [63:0] span, input logic [63:0] file_sz,
                             input logic [63:0] gap_lim);
    program_limit(REG_LIMIT_RECORDS, recs);
    program_limit(REG_LIMIT_PAYLOAD, payload);
    program_limit(REG_LIMIT_SPAN, span);
    program_limit(REG_LIMIT_FILE, file_sz);
    program_limit(REG_LIMIT_IDLE_GAP, gap_lim);
  endtask

  initial begin
    record_t     rec;
    logic [63:0] stamp;
    int          roll;
    pace_t       pace;

    stamp = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---------------- directed pass, no idling ----------------
    // all limits off after reset: extremes of both fields, no rotation
    send_record(record_t'{64'd0, 16'd0});
    send_record(record_t'{64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF});
    // earlier than the shard's latest time
    send_record(record_t'{64'd100, 16'd1});

    // record-count limit closes the three-record shard
    quiesce();
    program_limit(REG_LIMIT_RECORDS, 64'd3);
    send_record(record_t'{64'd50, 16'd7});

    // payload limit: landing exactly on it is fine, one byte past trips
    quiesce();
    program_limit(REG_LIMIT_RECORDS, 64'd0);
    program_limit(REG_LIMIT_PAYLOAD, 64'd100);
    send_record(record_t'{64'd10, 16'd60});
    send_record(record_t'{64'd20, 16'd33});
    send_record(record_t'{64'd30, 16'd1});

    // span limit, then an out-of-order record that widens first time only
    quiesce();
    program_limit(REG_LIMIT_PAYLOAD, 64'd0);
    program_limit(REG_LIMIT_SPAN, 64'd1000);
    send_record(record_t'{64'd1000, 16'd0});
    send_record(record_t'{64'd5000, 16'd0});
    send_record(record_t'{64'd4500, 16'd0});

    // file size estimate: exactly at the limit, then over
    quiesce();
    program_limit(REG_LIMIT_SPAN, 64'd0);
    program_limit(REG_LIMIT_FILE, 64'd100);
    send_record(record_t'{64'd4600, 16'd16});
    send_record(record_t'{64'd4700, 16'd0});

    // idle gap: within, beyond, a record behind the latest time, huge gap
    quiesce();
    program_limit(REG_LIMIT_FILE, 64'd0);
    program_limit(REG_LIMIT_IDLE_GAP, 64'd50);
    send_record(record_t'{64'd4740, 16'd0});
    send_record(record_t'{64'd4800, 16'd0});
    send_record(record_t'{64'd4000, 16'd0});
    send_record(record_t'{64'hFFFF_FFFF_FFFF_FFFF, 16'd0});

    // priority order: everything at one, then drop the winner each time
    quiesce();
    program_all(64'd1, 64'd1, 64'd1, 64'd1, 64'd1);
    send_record(record_t'{64'd0, 16'd0});
    quiesce();
    program_limit(REG_LIMIT_RECORDS, 64'd0);
    send_record(record_t'{64'd0, 16'd2});
    quiesce();
    program_limit(REG_LIMIT_PAYLOAD, 64'd0);
    send_record(record_t'{64'd5, 16'd0});
    quiesce();
    program_limit(REG_LIMIT_SPAN, 64'd0);
    program_limit(REG_LIMIT_FILE, 64'd0);
    send_record(record_t'{64'd7, 16'd0});

    // write past the register list must change nothing
    quiesce();
    program_limit(REG_LIMIT_IDLE_GAP, 64'd0);
    program_limit(REG_UNUSED, 64'd1);
    send_record(record_t'{64'd8, 16'd5});

    // ---------------- random phases ----------------
    for (int phase = 0; phase < PHASES; phase++) begin
      quiesce();
      case (phase)
        // register extremes, upper bits beyond each width included
        1: program_all('1, '1, '1, '1, '1);
        // smallest nonzero limits, almost every record rotates
        2: program_all(64'd1, 64'd1, 64'd1, 64'd1, 64'd1);
        3: program_all('0, '0, '0, '0, '0);
        default: begin
          // each limit off with some odds, else small enough to trip often
          program_all(($urandom_range(9) < 4) ? 64'd0 : 64'($urandom_range(1, 16)),
                      ($urandom_range(9) < 4) ? 64'd0 : 64'($urandom_range(1, 20000)),
                      ($urandom_range(9) < 4) ? 64'd0 : 64'($urandom_range(100, 4000)),
                      ($urandom_range(9) < 4) ? 64'd0 : 64'($urandom_range(36, 20000)),
                      ($urandom_range(9) < 4) ? 64'd0 : 64'($urandom_range(50, 600)));
        end
      endcase

      pace = pace_t'(phase % 4);
      case (pace)
        PACE_STEADY: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        PACE_SENDER_IDLE: begin
          tx_idle_pct  = 70;
          rx_stall_pct = 0;
        end
        PACE_RECEIVER_STALL: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 70;
        end
        default: begin
          tx_idle_pct  = 9;
          rx_stall_pct = 9;
        end
      endcase

      // long receiver hold-off while records keep coming, block backs up
      if (phase == 4) hold_go <= hold_go + 1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender goes quiet until everything owed has come back
        if (phase == 5 && n == PHASE_ITEMS / 2) quiesce();

        // timestamps mostly creep forward, with jumps, stragglers and near-max
        roll = $urandom_range(99);
        if (roll < 4) begin
          stamp = {$urandom, $urandom};
          rec.capture_time = stamp;
        end else if (roll < 7) begin
          stamp = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(2000));
          rec.capture_time = stamp;
        end else if (roll < 15) begin
          rec.capture_time = stamp - 64'($urandom_range(300));
        end else begin
          stamp = stamp + 64'($urandom_range(400));
          rec.capture_time = stamp;
        end

        roll = $urandom_range(99);
        if (roll < 70)      rec.payload_length = 16'($urandom_range(1500));
        else if (roll < 80) rec.payload_length = 16'd0;
        else if (roll < 90) rec.payload_length = 16'hFFFF;
        else                rec.payload_length = 16'($urandom);

        send_record(rec);
      end
    end

    quiesce();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;

    $display("run covered %0d records (directed pass plus %0d paced phases), %0d beats checked",
             sent, PHASES, checked);
    $display("%0d shard rotations seen in %0d cycles", rotations, cycles);
    if (failures == 0) begin
      $display("tb_capture_archive_rotation_segmenter_unit: PASS");
    end else begin
      $display("tb_capture_archive_rotation_segmenter_unit: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/carseg_pkg.sv
sv/carseg_csr.sv
sv/carseg_core.sv
sv/capture_archive_rotation_segmenter_unit.sv
tb/sv/shard_rotation_checker.sv
tb/sv/tb_capture_archive_rotation_segmenter_unit.sv
